// ----- rtl/core/gn3_pkg.sv -----
// Shared constants, opcodes and types of the 3-D gradient noise block.
package gn3_pkg;

	localparam int TABLE_BITS = 8;
	localparam int FRAC_BITS  = 16;
	localparam int GRAD_BITS  = 16;
	localparam int COORD_W    = 32;
	localparam int OUT_W      = 18;
	localparam int CORNERS    = 8;

	typedef enum logic [2:0] {
		OP_QUERY  = 3'd0,
		OP_PERM_X = 3'd1,
		OP_PERM_Y = 3'd2,
		OP_PERM_Z = 3'd3,
		OP_GRAD   = 3'd4
	} op_t;

	typedef struct packed {
		logic signed [GRAD_BITS-1:0] gx;
		logic signed [GRAD_BITS-1:0] gy;
		logic signed [GRAD_BITS-1:0] gz;
	} grad_t;

	typedef struct packed {
		logic                  we_x;
		logic                  we_y;
		logic                  we_z;
		logic                  we_g;
		logic [TABLE_BITS-1:0] idx;
		logic [TABLE_BITS-1:0] pv;
		grad_t                 grad;
	} load_t;

endpackage

// ----- rtl/core/gn3_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module gn3_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic          re,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	output logic [DW-1:0] rd0,
	output logic [DW-1:0] rd1
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd0 <= mem[ra0];
			rd1 <= mem[ra1];
		end
	end

endmodule

// ----- rtl/core/gn3_tables.sv -----
// Permutation and gradient tables: corner hashing and gradient fetch.
module gn3_tables import gn3_pkg::*; (
	input  logic                  clk,
	input  logic                  adv,
	input  load_t                 load,
	input  logic [TABLE_BITS-1:0] base_s0 [3],
	output grad_t                 grad_s2 [CORNERS]
);

	logic [TABLE_BITS-1:0] plo [3];
	logic [TABLE_BITS-1:0] phi [3];
	logic [TABLE_BITS-1:0] hash_s1 [CORNERS];
	logic [3*GRAD_BITS-1:0] grd [CORNERS];
	logic [2:0] pwe;

	assign pwe = {load.we_z, load.we_y, load.we_x};

	for (genvar a = 0; a < 3; a++) begin : g_perm
		gn3_ram #(.AW(TABLE_BITS), .DW(TABLE_BITS)) u_perm (
			.clk (clk),
			.we  (pwe[a]),
			.wa  (load.idx),
			.wd  (load.pv),
			.re  (adv),
			.ra0 (base_s0[a]),
			.ra1 (base_s0[a] + TABLE_BITS'(1)),
			.rd0 (plo[a]),
			.rd1 (phi[a])
		);
	end

	// corner k = {a, b, c}: pick lattice base or base + 1 per axis
	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			hash_s1[k] = (k[2] ? phi[0] : plo[0]) ^ (k[1] ? phi[1] : plo[1])
				^ (k[0] ? phi[2] : plo[2]);
		end
	end

	// four copies of the gradient table serve eight reads a cycle
	for (genvar j = 0; j < CORNERS / 2; j++) begin : g_grad
		gn3_ram #(.AW(TABLE_BITS), .DW(3 * GRAD_BITS)) u_grad (
			.clk (clk),
			.we  (load.we_g),
			.wa  (load.idx),
			.wd  (load.grad),
			.re  (adv),
			.ra0 (hash_s1[2*j]),
			.ra1 (hash_s1[2*j+1]),
			.rd0 (grd[2*j]),
			.rd1 (grd[2*j+1])
		);
	end

	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			grad_s2[k] = grad_t'(grd[k]);
		end
	end

endmodule

// ----- rtl/core/gn3_blend.sv -----
// Smoothstep weights, corner dot products and trilinear blend with saturation.
module gn3_blend import gn3_pkg::*; (
	input  logic                    clk,
	input  logic                    adv,
	input  logic [FRAC_BITS-1:0]    frac_s0 [3],
	input  grad_t                   grad_s2 [CORNERS],
	output logic signed [OUT_W-1:0] noise_s6
);

	localparam int F  = FRAC_BITS;
	localparam int PW = GRAD_BITS + F + 2;
	localparam int DW = F + 5;
	localparam int SW = 2 * F + 10;
	localparam logic [F+1:0] THREE = (F + 2)'(3) << F;
	localparam logic signed [F+1:0] ONE = (F + 2)'(1) << F;
	localparam logic signed [SW-F-1:0] SAT_MAX = (SW - F)'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SW-F-1:0] SAT_MIN = -(SW - F)'(1 << (OUT_W - 1));

	logic [F-1:0]           fr_s1 [3];
	logic [F-1:0]           fr_s2 [3];
	logic [F-1:0]           f2_s2 [3];
	logic [F+1:0]           s_s3 [3];
	logic [F+1:0]           s_s4;
	logic signed [PW-1:0]   prod_s3 [CORNERS][3];
	logic signed [DW-1:0]   d_s4 [CORNERS];
	logic signed [DW-1:0]   d_s5 [CORNERS];
	logic signed [F+3:0]    wab_s4 [4];
	logic signed [F+1:0]    w_s5 [CORNERS];
	logic signed [2*F+6:0]  p_s6 [CORNERS];

	logic [2*F-1:0]         sq [3];
	logic [F+1:0]           t [3];
	logic [2*F+1:0]         sm [3];
	logic signed [F+1:0]    off [CORNERS][3];
	logic signed [PW+1:0]   dot [CORNERS];
	logic signed [F+1:0]    wt [2][3];
	logic signed [2*F+3:0]  pab [4];
	logic signed [2*F+5:0]  pw [CORNERS];
	logic signed [SW-1:0]   acc;
	logic signed [SW-F-1:0] acc_sh;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sq[a] = fr_s1[a] * fr_s1[a];
			t[a]  = THREE - {1'b0, fr_s2[a], 1'b0};
			sm[a] = f2_s2[a] * t[a];
		end
		// x and y weights pair up in the stage before the z weight joins
		for (int a = 0; a < 2; a++) begin
			wt[1][a] = $signed(s_s3[a]);
			wt[0][a] = ONE - $signed(s_s3[a]);
		end
		wt[1][2] = $signed(s_s4);
		wt[0][2] = ONE - $signed(s_s4);
		for (int k = 0; k < CORNERS; k++) begin
			off[k][0] = $signed({2'b00, fr_s2[0]}) - (k[2] ? ONE : '0);
			off[k][1] = $signed({2'b00, fr_s2[1]}) - (k[1] ? ONE : '0);
			off[k][2] = $signed({2'b00, fr_s2[2]}) - (k[0] ? ONE : '0);
			dot[k] = PW'(0) + prod_s3[k][0] + prod_s3[k][1] + prod_s3[k][2];
		end
		for (int ab = 0; ab < 4; ab++) begin
			pab[ab] = wt[ab / 2][0] * wt[ab % 2][1];
		end
		for (int k = 0; k < CORNERS; k++) begin
			pw[k] = wab_s4[k / 2] * wt[k % 2][2];
		end
		acc = '0;
		for (int k = 0; k < CORNERS; k++) begin
			acc = acc + SW'(p_s6[k]);
		end
		acc_sh = acc[SW-1:F];
		if (acc_sh > SAT_MAX) begin
			noise_s6 = OUT_W'(SAT_MAX);
		end else if (acc_sh < SAT_MIN) begin
			noise_s6 = OUT_W'(SAT_MIN);
		end else begin
			noise_s6 = acc_sh[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				fr_s1[a] <= frac_s0[a];
				fr_s2[a] <= fr_s1[a];
				f2_s2[a] <= sq[a][2*F-1:F];
				s_s3[a]  <= sm[a][2*F+1:F];
			end
			s_s4 <= s_s3[2];
			for (int k = 0; k < CORNERS; k++) begin
				prod_s3[k][0] <= PW'(grad_s2[k].gx * off[k][0]);
				prod_s3[k][1] <= PW'(grad_s2[k].gy * off[k][1]);
				prod_s3[k][2] <= PW'(grad_s2[k].gz * off[k][2]);
				d_s4[k] <= dot[k][PW+1:GRAD_BITS-1];
				d_s5[k] <= d_s4[k];
				w_s5[k] <= pw[k][2*F+1:F];
				p_s6[k] <= w_s5[k] * d_s5[k];
			end
			for (int ab = 0; ab < 4; ab++) begin
				wab_s4[ab] <= pab[ab][2*F+3:F];
			end
		end
	end

endmodule

// ----- rtl/core/gradient_noise_3d.sv -----
// Top level of the 3-D gradient noise block: handshake, load decode, pipeline.
//
// Input channel (in_valid / in_stall) carries one beat per item. Opcodes 1 to 3
// write a permutation entry, opcode 4 writes a gradient entry; these produce
// no result. Opcode 0 is a noise query with a Q16.16 point; opcodes 5 to 7
// are dropped. Every table entry that a query touches must be loaded first.
// Output channel (out_valid / out_stall) carries one beat of noise_value in
// Q2.16 per query, in query order.
// Throughput: one item per cycle while in_stall is low. Each query fetches two
// permutation entries per axis from dual-read tables and eight gradients from
// four copies of the dual-read gradient table, so the tables set no limit.
// A query passes the permutation read, the gradient read, four arithmetic
// stages and the output register, in that order.
// The whole pipeline advances in lockstep; it holds, and in_stall rises, only
// while a result waits in the output register and out_stall is high.
// Loads write the tables at the edge they are accepted, so a later query
// sees them and an earlier query in flight does not.
// Reset clears the valid bits of the pipeline and the output register; the
// tables are not cleared and need loading after reset.
module gradient_noise_3d import gn3_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                opcode,
	input  logic [TABLE_BITS-1:0]     entry_index,
	input  logic [TABLE_BITS-1:0]     perm_entry,
	input  logic signed [GRAD_BITS-1:0] grad_x,
	input  logic signed [GRAD_BITS-1:0] grad_y,
	input  logic signed [GRAD_BITS-1:0] grad_z,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_W-1:0]   noise_value
);

	logic                    adv;
	logic                    accept;
	load_t                   load;
	logic [TABLE_BITS-1:0]   base_s0 [3];
	logic [FRAC_BITS-1:0]    frac_s0 [3];
	grad_t                   grad_s2 [CORNERS];
	logic signed [OUT_W-1:0] noise_s6;
	logic [6:1]              v_q;
	logic                    out_v_q;
	logic signed [OUT_W-1:0] noise_q;

	// advance everything unless a result waits and the receiver stalls
	assign adv      = !out_v_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_comb begin
		load.we_x    = accept && (op_t'(opcode) == OP_PERM_X);
		load.we_y    = accept && (op_t'(opcode) == OP_PERM_Y);
		load.we_z    = accept && (op_t'(opcode) == OP_PERM_Z);
		load.we_g    = accept && (op_t'(opcode) == OP_GRAD);
		load.idx     = entry_index;
		load.pv      = perm_entry;
		load.grad.gx = grad_x;
		load.grad.gy = grad_y;
		load.grad.gz = grad_z;
	end

	// floor is the integer part, wrapped to the table size; fraction is the rest
	always_comb begin
		base_s0[0] = coord_x[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
		base_s0[1] = coord_y[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
		base_s0[2] = coord_z[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
		frac_s0[0] = coord_x[FRAC_BITS-1:0];
		frac_s0[1] = coord_y[FRAC_BITS-1:0];
		frac_s0[2] = coord_z[FRAC_BITS-1:0];
	end

	gn3_tables u_tables (
		.clk     (clk),
		.adv     (adv),
		.load    (load),
		.base_s0 (base_s0),
		.grad_s2 (grad_s2)
	);

	gn3_blend u_blend (
		.clk      (clk),
		.adv      (adv),
		.frac_s0  (frac_s0),
		.grad_s2  (grad_s2),
		.noise_s6 (noise_s6)
	);

	// track which pipeline slots hold a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_q     <= {v_q[5:1], accept && (op_t'(opcode) == OP_QUERY)};
			out_v_q <= v_q[6];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= noise_s6;
		end
	end

	assign out_valid   = out_v_q;
	assign noise_value = noise_q;

endmodule
